// ===== rtl/lsa_pkg.sv =====
package lsa_pkg;

  localparam int unsigned ORDER = 4;
  localparam int unsigned IDX_W = 2;
  localparam int unsigned CELLS = ORDER * ORDER;
  localparam int unsigned CELL_W = 4;
  localparam int unsigned PACK_W = 8;

  typedef logic [IDX_W-1:0] elem_t;
  typedef elem_t [ORDER-1:0] perm_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADVANCE,
    ST_FOUND,
    ST_EXHAUST,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic restart;
    logic write_cell;
    logic clear_cell;
    logic step_cell;
    logic advance;
    logic set_started;
    logic set_done;
    logic load_found;
    logic load_exhaust;
  } dp_cmd_t;

  typedef struct packed {
    logic started;
    logic done;
    logic last_cell;
    logic cell_ok;
    logic wrapped;
  } dp_status_t;

  function automatic perm_t identity_perm();
    perm_t p;
    for (int k = 0; k < ORDER; k++) begin
      p[k] = elem_t'(k);
    end
    return p;
  endfunction

  // next permutation in lexicographic order; wraps to identity
  function automatic perm_t next_perm(input perm_t p, output logic wrapped);
    perm_t r;
    int piv;
    int sw;
    elem_t t;
    r = p;
    piv = -1;
    sw = 0;
    for (int i = 0; i < ORDER - 1; i++) begin
      if (p[i] < p[i+1]) begin
        piv = i;
      end
    end
    wrapped = (piv < 0);
    if (piv >= 0) begin
      for (int j = 0; j < ORDER; j++) begin
        if (j > piv && p[j] > p[piv]) begin
          sw = j;
        end
      end
      t = r[piv];
      r[piv] = r[sw];
      r[sw] = t;
    end
    p = r;
    for (int k = 0; k < ORDER; k++) begin
      if (k > piv) begin
        r[k] = p[ORDER - 1 - k + piv + 1];
      end
    end
    return r;
  endfunction

  function automatic elem_t inv_elem(input perm_t p, input elem_t v);
    elem_t r;
    r = '0;
    for (int k = 0; k < ORDER; k++) begin
      if (p[k] == v) begin
        r = elem_t'(k);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/lsa_ram.sv =====
module lsa_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lsa_datapath.sv =====
module lsa_datapath
  import lsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [IDX_W-1:0]     wr_row,
  input  logic [IDX_W-1:0]     wr_col,
  input  logic [IDX_W-1:0]     wr_value,
  output logic                 found,
  output logic                 exhausted,
  output logic [PACK_W-1:0]    row_perm,
  output logic [PACK_W-1:0]    col_perm,
  output logic [PACK_W-1:0]    symbol_perm
);

  perm_t rp, cp, sp;
  logic started, done;
  logic [CELL_W-1:0] cell_idx;
  logic ok;

  // Two RAM copies give two reads per cycle: target and source cell.
  logic [CELL_W-1:0] src_addr, wr_addr;
  logic [IDX_W-1:0] tgt_q, src_q;
  elem_t si, sj, ci, cj;
  logic cell_valid;

  assign ci = cell_idx[CELL_W-1:IDX_W];
  assign cj = cell_idx[IDX_W-1:0];
  assign si = inv_elem(rp, ci);
  assign sj = inv_elem(cp, cj);
  assign src_addr = {si, sj};
  assign wr_addr = {wr_row, wr_col};

  lsa_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_tgt (
    .clk, .we(cmd.write_cell), .waddr(wr_addr), .wdata(wr_value),
    .raddr(cell_idx), .rdata(tgt_q)
  );
  lsa_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_src (
    .clk, .we(cmd.write_cell), .waddr(wr_addr), .wdata(wr_value),
    .raddr(src_addr), .rdata(src_q)
  );

  logic wr_s, wr_c, wr_r;
  perm_t sp_n, cp_n, rp_n;
  always_comb begin
    sp_n = next_perm(sp, wr_s);
    cp_n = next_perm(cp, wr_c);
    rp_n = next_perm(rp, wr_r);
  end

  logic last_q;
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      rp <= identity_perm();
      cp <= identity_perm();
      sp <= identity_perm();
      started <= 1'b0;
      done <= 1'b0;
      cell_idx <= '0;
      cell_valid <= 1'b0;
      ok <= 1'b1;
      last_q <= 1'b0;
    end else begin
      if (cmd.set_started) started <= 1'b1;
      if (cmd.set_done) done <= 1'b1;
      if (cmd.clear_cell) begin
        cell_idx <= '0;
        cell_valid <= 1'b0;
        ok <= 1'b1;
        last_q <= 1'b0;
      end else if (cmd.step_cell) begin
        cell_idx <= cell_idx + 1'b1;
        cell_valid <= 1'b1;
        last_q <= (cell_idx == CELL_W'(CELLS - 1));
        if (cell_valid && (tgt_q != inv_elem(sp, src_q))) ok <= 1'b0;
      end
      if (cmd.advance) begin
        sp <= sp_n;
        if (wr_s) begin
          cp <= cp_n;
          if (wr_c) rp <= rp_n;
        end
      end
    end
  end

  assign status.started = started;
  assign status.done = done;
  assign status.last_cell = last_q;
  assign status.cell_ok = ok && !(cell_valid && tgt_q != inv_elem(sp, src_q));
  assign status.wrapped = wr_s && wr_c && wr_r;

  always_ff @(posedge clk) begin
    if (cmd.load_found) begin
      found <= 1'b1;
      exhausted <= 1'b0;
      for (int k = 0; k < ORDER; k++) begin
        row_perm[IDX_W*k +: IDX_W] <= rp[k];
        col_perm[IDX_W*k +: IDX_W] <= cp[k];
        symbol_perm[IDX_W*k +: IDX_W] <= sp[k];
      end
    end else if (cmd.load_exhaust) begin
      found <= 1'b0;
      exhausted <= 1'b1;
      row_perm <= '0;
      col_perm <= '0;
      symbol_perm <= '0;
    end
  end

endmodule

// ===== rtl/lsa_ctrl.sv =====
module lsa_ctrl
  import lsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_op,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_WRITE) begin
            cmd.write_cell = 1'b1;
            cmd.restart = 1'b1;
          end else if (status.done) begin
            cmd.load_exhaust = 1'b1;
            state_next = ST_OUT;
          end else begin
            cmd.clear_cell = 1'b1;
            cmd.set_started = 1'b1;
            if (status.started) begin
              state_next = ST_ADVANCE;
            end else begin
              state_next = ST_CHECK;
            end
          end
        end
      end
      ST_ADVANCE: begin
        cmd.advance = 1'b1;
        cmd.clear_cell = 1'b1;
        state_next = status.wrapped ? ST_EXHAUST : ST_CHECK;
      end
      ST_CHECK: begin
        // stream every cell through both RAMs, one per cycle
        if (status.last_cell) begin
          state_next = status.cell_ok ? ST_FOUND : ST_ADVANCE;
        end else begin
          cmd.step_cell = 1'b1;
        end
      end
      ST_FOUND: begin
        cmd.load_found = 1'b1;
        state_next = ST_OUT;
      end
      ST_EXHAUST: begin
        cmd.set_done = 1'b1;
        cmd.load_exhaust = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/latin_square_autotopy_search.sv =====
// Latin square autotopy search.
// Slave channel s_axis_*: one transaction per command. tuser carries opcode
// (0 writes a cell, 1 searches); tdata carries cell_row, cell_col, cell_value.
// A write restarts the walk and produces no result. Writes outside the square
// cannot occur at ORDER 4 since the 2-bit indices cover it.
// Master channel m_axis_*: one transaction per search. tuser holds found and
// exhausted; tdata holds row_perm, col_perm, symbol_perm.
// For each candidate triple the cells stream through two copies of the square
// RAM, one cell per cycle. A search walks up to (ORDER!)^3 triples.
// Reset restores identity permutations; the square holds garbage until
// written. While the result waits for m_axis_tready the block accepts no
// new command.
module latin_square_autotopy_search
  import lsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // cell_row[1:0], cell_col[3:2], cell_value[5:4]
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // row_perm[7:0], col_perm[15:8], symbol_perm[23:16]
  output logic [1:0]  m_axis_tuser   // found[0], exhausted[1]
);

  dp_cmd_t cmd;
  dp_status_t status;
  logic found, exhausted;
  logic [PACK_W-1:0] row_perm, col_perm, symbol_perm;

  lsa_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_op(s_axis_tuser), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd, .status
  );

  lsa_datapath u_dp (
    .clk, .rst, .cmd, .status,
    .wr_row(s_axis_tdata[1:0]), .wr_col(s_axis_tdata[3:2]),
    .wr_value(s_axis_tdata[5:4]),
    .found, .exhausted, .row_perm, .col_perm, .symbol_perm
  );

  assign m_axis_tdata = {symbol_perm, col_perm, row_perm};
  assign m_axis_tuser = {exhausted, found};

endmodule
